>>> hw/rtl/smpd_pkg.sv
// Package with the types and constants of the serial mouse packet decoder.
package smpd_pkg;

  // Where the decoder stands within a five-byte packet.
  typedef enum logic [2:0] {
    POS_HUNT = 3'd0,
    POS_X1   = 3'd1,
    POS_Y1   = 3'd2,
    POS_X2   = 3'd3,
    POS_Y2   = 3'd4
  } pos_t;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BUTTON_W = 3;

  // Bit 7 marks the first byte of a packet.
  localparam int unsigned SYNC_BIT = 7;

  // Button bit positions, both in byte one and in the sticky down flags.
  localparam int unsigned LEFT_BIT   = 2;
  localparam int unsigned MIDDLE_BIT = 1;
  localparam int unsigned RIGHT_BIT  = 0;

endpackage

>>> hw/rtl/serial_mouse_packet_decoder_top.sv
// Top level of the five-byte serial mouse packet decoder.
//
// Usage: received serial bytes enter on the rx channel (rx_byte with
// rx_valid and rx_ready), one request per byte. While hunting, a byte with
// bit 7 clear is dropped; a byte with bit 7 set opens a packet, and the
// next four bytes are taken whatever their value. The fifth byte yields
// one request on the result channel (res_valid and res_ready) carrying
// dx, dy, the three button levels and the three release flags.
//
// The result is registered and appears in the cycle after the fifth byte is accepted.
// Throughput: one byte per cycle, set by the single result register that
// follows the packet logic; a new byte is taken while a result still waits,
// as long as the receiver drains it in the same cycle.
//
// Reset puts the decoder back to hunting, clears the sticky down flags and
// empties the result register. When the receiver stalls, the result is
// held unchanged and rx_ready stays low until it is taken, so no byte is
// lost and no result is overwritten.
module serial_mouse_packet_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  input  logic [smpd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [7:0]             dx,
  output logic signed [8:0]             dy,
  output logic                          left_pressed,
  output logic                          middle_pressed,
  output logic                          right_pressed,
  output logic                          left_released,
  output logic                          middle_released,
  output logic                          right_released
);
  import smpd_pkg::*;

  // Packet position and captured bytes.
  pos_t                pos, pos_next;
  logic [BUTTON_W-1:0] button_bits, button_bits_next;
  logic [BYTE_W-1:0]   first_x_byte, first_x_byte_next;
  logic [BYTE_W-1:0]   first_y_byte, first_y_byte_next;
  logic [BUTTON_W-1:0] buttons_down, buttons_down_next;

  logic                rx_take;
  logic                emit;
  logic [BYTE_W-1:0]   y_sum;
  logic [BUTTON_W-1:0] rel;

  // The result register can take a new value when it is empty or drained.
  assign rx_ready = !res_valid || res_ready;
  assign rx_take  = rx_valid && rx_ready;

  // The vertical sum of bytes three and five, negated after sign extension.
  assign y_sum = first_y_byte + rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_HUNT;
      buttons_down <= '0;
    end else begin
      pos          <= pos_next;
      buttons_down <= buttons_down_next;
    end
    button_bits  <= button_bits_next;
    first_x_byte <= first_x_byte_next;
    first_y_byte <= first_y_byte_next;
  end

  always_comb begin
    pos_next          = pos;
    button_bits_next  = button_bits;
    first_x_byte_next = first_x_byte;
    first_y_byte_next = first_y_byte;
    buttons_down_next = buttons_down;
    emit              = 1'b0;
    rel               = '0;
    if (rx_take) begin
      unique case (pos)
        POS_X1: begin
          first_x_byte_next = rx_byte;
          pos_next          = POS_Y1;
        end
        POS_Y1: begin
          first_y_byte_next = rx_byte;
          pos_next          = POS_X2;
        end
        POS_X2: begin
          first_x_byte_next = first_x_byte + rx_byte;
          pos_next          = POS_Y2;
        end
        POS_Y2: begin
          emit     = 1'b1;
          pos_next = POS_HUNT;
          // With no button held, every sticky flag is reported and cleared.
          if (button_bits == '0) begin
            rel               = buttons_down;
            buttons_down_next = '0;
          end else begin
            buttons_down_next = buttons_down | button_bits;
          end
        end
        default: begin
          if (rx_byte[SYNC_BIT]) begin
            button_bits_next = ~rx_byte[BUTTON_W-1:0];
            pos_next         = POS_X1;
          end else begin
            pos_next = POS_HUNT;
          end
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (emit) begin
      dx              <= $signed(first_x_byte);
      dy              <= -$signed({y_sum[BYTE_W-1], y_sum});
      left_pressed    <= button_bits[LEFT_BIT];
      middle_pressed  <= button_bits[MIDDLE_BIT];
      right_pressed   <= button_bits[RIGHT_BIT];
      left_released   <= rel[LEFT_BIT];
      middle_released <= rel[MIDDLE_BIT];
      right_released  <= rel[RIGHT_BIT];
    end
  end

endmodule

>>> hw/rtl/smpd_checker.sv
// Port checker for the serial mouse packet decoder and its bind.
module smpd_checker (
  input logic              clk,
  input logic              rst,
  input logic              rx_valid,
  input logic              rx_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic signed [7:0] dx,
  input logic signed [8:0] dy,
  input logic              left_pressed,
  input logic              middle_pressed,
  input logic              right_pressed,
  input logic              left_released,
  input logic              middle_released,
  input logic              right_released
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(dx) && $stable(dy))
    else $error("stalled result changed");

  // A new result only follows an accepted byte.
  a_rose_after_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_valid && rx_ready))
    else $error("result without an accepted byte");

  // A full, stalled result register blocks new bytes.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !rx_ready)
    else $error("byte taken while result stalls");

  // Releases are only reported in a packet with no button held.
  a_release_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid && (left_released || middle_released || right_released)
      |-> !left_pressed && !middle_pressed && !right_pressed)
    else $error("release reported while a button is held");

endmodule

bind serial_mouse_packet_decoder_top smpd_checker u_smpd_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_valid        (rx_valid),
  .rx_ready        (rx_ready),
  .res_valid       (res_valid),
  .res_ready       (res_ready),
  .dx              (dx),
  .dy              (dy),
  .left_pressed    (left_pressed),
  .middle_pressed  (middle_pressed),
  .right_pressed   (right_pressed),
  .left_released   (left_released),
  .middle_released (middle_released),
  .right_released  (right_released)
);
